FILE: hdl/conditional_blob_label_dilation_core_defines.svh
// assertion macros used by the checker
`ifndef CONDITIONAL_BLOB_LABEL_DILATION_CORE_DEFINES_SVH
`define CONDITIONAL_BLOB_LABEL_DILATION_CORE_DEFINES_SVH

// same-cycle implication, off while reset is held
`define CBLD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define CBLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// same-cycle implication, checked through reset as well
`define CBLD_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cbld_pkg.sv
`default_nettype none

package cbld_pkg;

    localparam int MAX_BOX_WIDTH  = 64;
    localparam int MAX_BOX_HEIGHT = 64;
    localparam int MAX_WINDOW     = 15;

    localparam int STORE_DEPTH = MAX_BOX_WIDTH * MAX_BOX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int AREA_W      = $clog2(STORE_DEPTH + 1);

    localparam int LABEL_W = 17;
    localparam int ID_W    = 16;
    localparam int VALUE_W = 8;
    localparam int COORD_W = 6;
    localparam int BOUND_W = COORD_W + 1;
    localparam int DIM_W   = 7;
    localparam int WIN_W   = 4;
    localparam int RAM_W   = LABEL_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CFG_BLOB_ID     = 2'd0,
        CFG_WINDOW_SIZE = 2'd1,
        CFG_BOX_WIDTH   = 2'd2,
        CFG_BOX_HEIGHT  = 2'd3
    } t_cfg_index;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CENTER,
        ST_SCAN
    } t_state;

    // effective geometry after clamping
    typedef struct packed {
        logic [ID_W-1:0]   blob_id;
        logic [WIN_W-1:0]  win;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [AREA_W-1:0] area;
    } t_geom;

    // one classified word between front and back
    typedef struct packed {
        t_opcode              op;
        logic                 nz;
        logic [LABEL_W-1:0]   label;
        logic [ADDR_W-1:0]    center;
        logic [ADDR_W-1:0]    base;
        logic [COORD_W-1:0]   r0;
        logic [BOUND_W-1:0]   r1;
        logic [COORD_W-1:0]   c0;
        logic [BOUND_W-1:0]   c1;
    } t_task;

endpackage

`default_nettype wire

FILE: hdl/cbld_ram.sv
`default_nettype none

module cbld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/cbld_queue.sv
`default_nettype none

module cbld_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  cbld_pkg::t_task     i_task,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output cbld_pkg::t_task     o_head
);

    cbld_pkg::t_task                  r_mem [cbld_pkg::QUEUE_DEPTH];
    logic [cbld_pkg::QPTR_W-1:0]      r_wptr, n_wptr;
    logic [cbld_pkg::QPTR_W-1:0]      r_rptr, n_rptr;
    logic [cbld_pkg::QCNT_W-1:0]      r_count, n_count;
    logic                             do_push, do_pop;

    assign o_full  = (r_count == cbld_pkg::QCNT_W'(cbld_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_task;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cbld_front.sv
`default_nettype none

module cbld_front (
    input  wire logic                           i_push,
    input  wire logic                           i_full,
    input  wire logic                           i_opcode,
    input  wire logic [cbld_pkg::VALUE_W-1:0]   i_pixel_value,
    input  wire logic [cbld_pkg::LABEL_W-1:0]   i_pixel_label,
    input  wire logic [cbld_pkg::COORD_W-1:0]   i_query_row,
    input  wire logic [cbld_pkg::COORD_W-1:0]   i_query_col,
    input  cbld_pkg::t_geom                     i_geom,
    output logic                                o_enq,
    output cbld_pkg::t_task                     o_task
);

    logic                             in_box;
    logic [cbld_pkg::COORD_W-1:0]     win;
    logic [cbld_pkg::COORD_W-1:0]     r0, c0;
    logic [cbld_pkg::BOUND_W-1:0]     row_plus, col_plus;
    logic [cbld_pkg::BOUND_W-1:0]     r1, c1;
    logic [cbld_pkg::AREA_W:0]        center_full;
    logic [cbld_pkg::AREA_W:0]        base_full;

    always_comb begin
        win    = cbld_pkg::COORD_W'(i_geom.win);
        in_box = (cbld_pkg::DIM_W'(i_query_row) < i_geom.height)
              && (cbld_pkg::DIM_W'(i_query_col) < i_geom.width);

        // window rows r-s .. r+s-1 and columns c-s .. c+s-1, clipped
        r0       = (i_query_row > win) ? i_query_row - win : '0;
        c0       = (i_query_col > win) ? i_query_col - win : '0;
        row_plus = cbld_pkg::BOUND_W'(i_query_row) + cbld_pkg::BOUND_W'(win);
        col_plus = cbld_pkg::BOUND_W'(i_query_col) + cbld_pkg::BOUND_W'(win);
        r1       = (row_plus < cbld_pkg::BOUND_W'(i_geom.height))
                 ? row_plus : cbld_pkg::BOUND_W'(i_geom.height);
        c1       = (col_plus < cbld_pkg::BOUND_W'(i_geom.width))
                 ? col_plus : cbld_pkg::BOUND_W'(i_geom.width);

        center_full = (cbld_pkg::AREA_W+1)'(i_query_row) * (cbld_pkg::AREA_W+1)'(i_geom.width)
                    + (cbld_pkg::AREA_W+1)'(i_query_col);
        base_full   = (cbld_pkg::AREA_W+1)'(r0) * (cbld_pkg::AREA_W+1)'(i_geom.width);

        o_task.op     = cbld_pkg::t_opcode'(i_opcode);
        o_task.nz     = (i_pixel_value != '0);
        o_task.label  = i_pixel_label;
        o_task.center = center_full[cbld_pkg::ADDR_W-1:0];
        o_task.base   = base_full[cbld_pkg::ADDR_W-1:0];
        o_task.r0     = r0;
        o_task.r1     = r1;
        o_task.c0     = c0;
        o_task.c1     = c1;

        // queries outside the box are dropped here
        o_enq = i_push && !i_full
             && ((cbld_pkg::t_opcode'(i_opcode) == cbld_pkg::OP_LOAD) || in_box);
    end

endmodule

`default_nettype wire

FILE: hdl/cbld_back.sv
`default_nettype none

module cbld_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  cbld_pkg::t_geom                     i_geom,
    input  wire logic                           i_q_empty,
    input  cbld_pkg::t_task                     i_q_head,
    output logic                                o_q_pop,
    input  wire logic                           i_pop,
    output logic                                o_empty,
    output logic [cbld_pkg::LABEL_W-1:0]        o_new_label,
    output logic                                o_dilated
);

    cbld_pkg::t_state                   r_state, n_state;
    cbld_pkg::t_task                    r_task, n_task;
    logic [cbld_pkg::ADDR_W-1:0]        r_pos, n_pos;
    logic [cbld_pkg::LABEL_W-1:0]       r_center, n_center;
    logic [cbld_pkg::BOUND_W-1:0]       r_wr, n_wr;
    logic [cbld_pkg::BOUND_W-1:0]       r_wc, n_wc;
    logic [cbld_pkg::AREA_W-1:0]        r_base, n_base;
    logic                               r_pend, n_pend;
    logic                               r_done, n_done;
    logic                               r_out_full, n_out_full;
    logic [cbld_pkg::LABEL_W-1:0]       r_out_label, n_out_label;
    logic                               r_out_dil, n_out_dil;

    logic                               we, re;
    logic [cbld_pkg::ADDR_W-1:0]        waddr, raddr;
    logic [cbld_pkg::RAM_W-1:0]         wdata, rdata;
    logic [cbld_pkg::LABEL_W-1:0]       rd_label, id_word;
    logic                               rd_nz;
    logic [cbld_pkg::ADDR_W-1:0]        pos_w;
    logic [cbld_pkg::AREA_W-1:0]        pos_inc, scan_addr;
    logic                               last_col;

    cbld_ram #(
        .WIDTH (cbld_pkg::RAM_W),
        .DEPTH (cbld_pkg::STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_label = rdata[cbld_pkg::RAM_W-1:1];
    assign rd_nz    = rdata[0];
    assign id_word  = cbld_pkg::LABEL_W'(i_geom.blob_id);

    assign o_empty     = !r_out_full;
    assign o_new_label = r_out_label;
    assign o_dilated   = r_out_dil;

    always_comb begin
        n_state     = r_state;
        n_task      = r_task;
        n_pos       = r_pos;
        n_center    = r_center;
        n_wr        = r_wr;
        n_wc        = r_wc;
        n_base      = r_base;
        n_pend      = r_pend;
        n_done      = r_done;
        n_out_full  = r_out_full && !i_pop;
        n_out_label = r_out_label;
        n_out_dil   = r_out_dil;
        o_q_pop     = 1'b0;
        we          = 1'b0;
        re          = 1'b0;
        waddr       = '0;
        raddr       = '0;
        wdata       = {i_q_head.label, i_q_head.nz};

        // load position wraps before and after the write
        pos_w     = (cbld_pkg::AREA_W'(r_pos) >= i_geom.area) ? '0 : r_pos;
        pos_inc   = cbld_pkg::AREA_W'(pos_w) + cbld_pkg::AREA_W'(1);
        scan_addr = r_base + cbld_pkg::AREA_W'(r_wc);
        last_col  = (r_wc + cbld_pkg::BOUND_W'(1)) >= r_task.c1;

        unique case (r_state)
            cbld_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_head.op == cbld_pkg::OP_LOAD) begin
                        we      = 1'b1;
                        waddr   = pos_w;
                        n_pos   = (pos_inc >= i_geom.area)
                                ? '0 : pos_inc[cbld_pkg::ADDR_W-1:0];
                        o_q_pop = 1'b1;
                    end else if (!r_out_full) begin
                        re      = 1'b1;
                        raddr   = i_q_head.center;
                        n_task  = i_q_head;
                        o_q_pop = 1'b1;
                        n_state = cbld_pkg::ST_CENTER;
                    end
                end
            end
            cbld_pkg::ST_CENTER: begin
                n_center = rd_label;
                if (rd_label[cbld_pkg::LABEL_W-1] && rd_nz
                    && (cbld_pkg::BOUND_W'(r_task.r0) < r_task.r1)
                    && (cbld_pkg::BOUND_W'(r_task.c0) < r_task.c1)) begin
                    n_wr    = cbld_pkg::BOUND_W'(r_task.r0);
                    n_wc    = cbld_pkg::BOUND_W'(r_task.c0);
                    n_base  = cbld_pkg::AREA_W'(r_task.base);
                    n_pend  = 1'b0;
                    n_done  = 1'b0;
                    n_state = cbld_pkg::ST_SCAN;
                end else begin
                    n_out_full  = 1'b1;
                    n_out_label = rd_label;
                    n_out_dil   = 1'b0;
                    n_state     = cbld_pkg::ST_IDLE;
                end
            end
            cbld_pkg::ST_SCAN: begin
                if (r_pend && (rd_label == id_word)) begin
                    n_out_full  = 1'b1;
                    n_out_label = id_word;
                    n_out_dil   = 1'b1;
                    n_state     = cbld_pkg::ST_IDLE;
                end else if (r_done) begin
                    n_out_full  = 1'b1;
                    n_out_label = r_center;
                    n_out_dil   = 1'b0;
                    n_state     = cbld_pkg::ST_IDLE;
                end else begin
                    re     = 1'b1;
                    raddr  = scan_addr[cbld_pkg::ADDR_W-1:0];
                    n_pend = 1'b1;
                    n_done = last_col && ((r_wr + cbld_pkg::BOUND_W'(1)) >= r_task.r1);
                    if (last_col) begin
                        n_wc   = cbld_pkg::BOUND_W'(r_task.c0);
                        n_wr   = r_wr + cbld_pkg::BOUND_W'(1);
                        n_base = r_base + cbld_pkg::AREA_W'(i_geom.width);
                    end else begin
                        n_wc   = r_wc + cbld_pkg::BOUND_W'(1);
                    end
                end
            end
            default: begin
                n_state = cbld_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cbld_pkg::ST_IDLE;
            r_pos      <= '0;
            r_pend     <= 1'b0;
            r_done     <= 1'b0;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_pend     <= n_pend;
            r_done     <= n_done;
            r_out_full <= n_out_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_task      <= n_task;
        r_center    <= n_center;
        r_wr        <= n_wr;
        r_wc        <= n_wc;
        r_base      <= n_base;
        r_out_label <= n_out_label;
        r_out_dil   <= n_out_dil;
    end

endmodule

`default_nettype wire

FILE: hdl/conditional_blob_label_dilation_core.sv
// conditional dilation of one labeled blob inside a bounding box. load words
// (opcode 0) write the next pixel of the box in raster order and give no
// result; query words (opcode 1) name one pixel and give one result word,
// except a query outside the box, which is dropped. an unassigned (negative
// label) nonzero pixel takes blob_id when any stored label in rows r-s..r+s-1
// and columns c-s..c+s-1 (clipped to the box) equals blob_id. the back end
// writes a load straight into the pixel store; a query reads its center pixel,
// then for an unassigned nonzero center the window pixels up to the first match,
// all via the single read port of the pixel store. the front end accepts words
// into a 4-deep queue while the back end works, and a finished result waits in
// an output register. pixels never loaded since reset read as garbage.

`default_nettype none

module conditional_blob_label_dilation_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input word queue
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              i_opcode,
    input  wire logic [cbld_pkg::VALUE_W-1:0]      i_pixel_value,
    input  wire logic signed [cbld_pkg::LABEL_W-1:0] i_pixel_label,
    input  wire logic [cbld_pkg::COORD_W-1:0]      i_query_row,
    input  wire logic [cbld_pkg::COORD_W-1:0]      i_query_col,
    // result word output register
    output logic                                   empty,
    input  wire logic                              pop,
    output logic signed [cbld_pkg::LABEL_W-1:0]    o_new_label,
    output logic                                   o_dilated,
    // register writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [1:0]                        i_cfg_index,
    input  wire logic [cbld_pkg::ID_W-1:0]         i_cfg_data
);

    // configuration registers
    logic [cbld_pkg::ID_W-1:0]    r_blob_id;
    logic [cbld_pkg::WIN_W-1:0]   r_win;
    logic [cbld_pkg::DIM_W-1:0]   r_box_w;
    logic [cbld_pkg::DIM_W-1:0]   r_box_h;

    cbld_pkg::t_geom              geom;
    logic [cbld_pkg::DIM_W-1:0]   eff_w, eff_h;
    logic [2*cbld_pkg::DIM_W-1:0] area_full;

    logic                         enq;
    cbld_pkg::t_task              enq_task;
    logic                         q_empty, q_pop;
    cbld_pkg::t_task              q_head;
    logic [cbld_pkg::LABEL_W-1:0] new_label;

    // writes are always accepted, straight into the registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blob_id <= '0;
            r_win     <= cbld_pkg::WIN_W'(1);
            r_box_w   <= cbld_pkg::DIM_W'(cbld_pkg::MAX_BOX_WIDTH);
            r_box_h   <= cbld_pkg::DIM_W'(cbld_pkg::MAX_BOX_HEIGHT);
        end else if (i_cfg_valid) begin
            unique case (cbld_pkg::t_cfg_index'(i_cfg_index))
                cbld_pkg::CFG_BLOB_ID:     r_blob_id <= i_cfg_data;
                cbld_pkg::CFG_WINDOW_SIZE: r_win     <= i_cfg_data[cbld_pkg::WIN_W-1:0];
                cbld_pkg::CFG_BOX_WIDTH:   r_box_w   <= i_cfg_data[cbld_pkg::DIM_W-1:0];
                cbld_pkg::CFG_BOX_HEIGHT:  r_box_h   <= i_cfg_data[cbld_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // zero box dimensions act as one, oversize ones and the window saturate
    always_comb begin
        if (r_box_w == '0) begin
            eff_w = cbld_pkg::DIM_W'(1);
        end else if (r_box_w > cbld_pkg::DIM_W'(cbld_pkg::MAX_BOX_WIDTH)) begin
            eff_w = cbld_pkg::DIM_W'(cbld_pkg::MAX_BOX_WIDTH);
        end else begin
            eff_w = r_box_w;
        end
        if (r_box_h == '0) begin
            eff_h = cbld_pkg::DIM_W'(1);
        end else if (r_box_h > cbld_pkg::DIM_W'(cbld_pkg::MAX_BOX_HEIGHT)) begin
            eff_h = cbld_pkg::DIM_W'(cbld_pkg::MAX_BOX_HEIGHT);
        end else begin
            eff_h = r_box_h;
        end
        area_full    = eff_w * eff_h;
        geom.blob_id = r_blob_id;
        geom.win     = (r_win > cbld_pkg::WIN_W'(cbld_pkg::MAX_WINDOW))
                     ? cbld_pkg::WIN_W'(cbld_pkg::MAX_WINDOW) : r_win;
        geom.width   = eff_w;
        geom.height  = eff_h;
        geom.area    = area_full[cbld_pkg::AREA_W-1:0];
    end

    // front end: classify and drop out-of-box queries
    cbld_front u_front (
        .i_push        (push),
        .i_full        (full),
        .i_opcode      (i_opcode),
        .i_pixel_value (i_pixel_value),
        .i_pixel_label (i_pixel_label),
        .i_query_row   (i_query_row),
        .i_query_col   (i_query_col),
        .i_geom        (geom),
        .o_enq         (enq),
        .o_task        (enq_task)
    );

    // decoupling queue between the two halves
    cbld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (enq),
        .i_task  (enq_task),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // back end: pixel store writes and window scans
    cbld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_new_label (new_label),
        .o_dilated   (o_dilated)
    );

    assign o_new_label = new_label;

endmodule

`default_nettype wire

FILE: hdl/cbld_checker.sv
`default_nettype none

`include "conditional_blob_label_dilation_core_defines.svh"

module cbld_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                full,
    input  wire logic                                empty,
    input  wire logic                                pop,
    input  wire logic signed [cbld_pkg::LABEL_W-1:0] o_new_label,
    input  wire logic                                o_dilated
);

    logic [cbld_pkg::LABEL_W:0] result_word;
    logic                       waiting;
    logic                       label_neg;

    assign result_word = {o_new_label, o_dilated};
    assign waiting     = !empty && !pop;
    assign label_neg   = o_new_label[cbld_pkg::LABEL_W-1];

    // the input queue and the result register come out of reset clear
    `CBLD_ASSERT_ALWAYS(a_reset_clear, $past(!i_rst_n), empty && !full, "not clear after reset")

    // a waiting result word holds until taken
    `CBLD_ASSERT_NEXT(a_result_hold, waiting, !empty && $stable(result_word), "held word changed")

    // a grown pixel always carries a non-negative blob id
    `CBLD_ASSERT_SAME(a_dilated_label, !empty && o_dilated, !label_neg, "negative grown label")

endmodule

bind conditional_blob_label_dilation_core cbld_checker u_cbld_checker (.*);

`default_nettype wire

FILE: dv/conditional_blob_label_dilation_core_tb.sv
`timescale 1ns / 1ps

module conditional_blob_label_dilation_core_tb;

    // kinds of pending work for the driver
    typedef enum logic [1:0] {
        K_WORD,
        K_REG,
        K_DRAIN
    } t_kind;

    typedef struct {
        t_kind                                kind;
        cbld_pkg::t_opcode                    op;
        logic [cbld_pkg::VALUE_W-1:0]         value;
        logic signed [cbld_pkg::LABEL_W-1:0]  label;
        logic [cbld_pkg::COORD_W-1:0]         row;
        logic [cbld_pkg::COORD_W-1:0]         col;
        cbld_pkg::t_cfg_index                 idx;
        logic [cbld_pkg::ID_W-1:0]            data;
    } t_pending;

    typedef struct {
        logic signed [cbld_pkg::LABEL_W-1:0]  label;
        logic                                 dilated;
    } t_dil_result;

    localparam int SETTLE = 32;    // cycles of quiet before a register write

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 push = 1'b0;
    logic                                 full;
    logic                                 i_opcode = cbld_pkg::OP_LOAD;
    logic [cbld_pkg::VALUE_W-1:0]         i_pixel_value = '0;
    logic signed [cbld_pkg::LABEL_W-1:0]  i_pixel_label = '0;
    logic [cbld_pkg::COORD_W-1:0]         i_query_row = '0;
    logic [cbld_pkg::COORD_W-1:0]         i_query_col = '0;
    logic                                 empty;
    logic                                 pop = 1'b0;
    logic signed [cbld_pkg::LABEL_W-1:0]  o_new_label;
    logic                                 o_dilated;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    logic [1:0]                           i_cfg_index = '0;
    logic [cbld_pkg::ID_W-1:0]            i_cfg_data = '0;

    conditional_blob_label_dilation_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_opcode      (i_opcode),
        .i_pixel_value (i_pixel_value),
        .i_pixel_label (i_pixel_label),
        .i_query_row   (i_query_row),
        .i_query_col   (i_query_col),
        .empty         (empty),
        .pop           (pop),
        .o_new_label   (o_new_label),
        .o_dilated     (o_dilated),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow of the block: pixel store, load pointer and registers
    // ------------------------------------------------------------------
    logic signed [cbld_pkg::LABEL_W-1:0]  shadow_label [cbld_pkg::STORE_DEPTH];
    logic                                 shadow_nz    [cbld_pkg::STORE_DEPTH];
    int                                   shadow_pos;
    logic [cbld_pkg::ID_W-1:0]            reg_blob_id;
    logic [cbld_pkg::WIN_W-1:0]           reg_window;
    logic [cbld_pkg::DIM_W-1:0]           reg_width;
    logic [cbld_pkg::DIM_W-1:0]           reg_height;

    t_pending     pending_words [$];
    t_dil_result  expected_labels [$];

    int errors;
    int mismatches;
    int n_loads;
    int n_queries;
    int n_results;
    int n_reg_writes;
    int n_phases;

    // clamp a box dimension the way the block does: zero acts as one,
    // anything past the maximum saturates
    function automatic int clamp_dim(logic [cbld_pkg::DIM_W-1:0] d, int max_d);
        if (d == 0) return 1;
        return (d > max_d) ? max_d : int'(d);
    endfunction

    function automatic void apply_reg(cbld_pkg::t_cfg_index idx,
                                      logic [cbld_pkg::ID_W-1:0] data);
        case (idx)
            cbld_pkg::CFG_BLOB_ID:     reg_blob_id = data;
            cbld_pkg::CFG_WINDOW_SIZE: reg_window  = data[cbld_pkg::WIN_W-1:0];
            cbld_pkg::CFG_BOX_WIDTH:   reg_width   = data[cbld_pkg::DIM_W-1:0];
            cbld_pkg::CFG_BOX_HEIGHT:  reg_height  = data[cbld_pkg::DIM_W-1:0];
            default: ;
        endcase
    endfunction

    // loads write the store in raster order, queries grow the blob into
    // an unassigned nonzero pixel when its window holds the blob id
    function automatic void dilate_word(t_pending w);
        int          bw;
        int          bh;
        int          area;
        int          s;
        int          r;
        int          c;
        int          r1;
        int          c1;
        bit          hit;
        t_dil_result res;
        bw = clamp_dim(reg_width, cbld_pkg::MAX_BOX_WIDTH);
        bh = clamp_dim(reg_height, cbld_pkg::MAX_BOX_HEIGHT);
        area = bw * bh;
        if (w.op == cbld_pkg::OP_LOAD) begin
            if (shadow_pos >= area) shadow_pos = 0;
            shadow_label[shadow_pos] = w.label;
            shadow_nz[shadow_pos] = (w.value != 0);
            shadow_pos++;
            if (shadow_pos >= area) shadow_pos = 0;
            n_loads++;
            return;
        end
        n_queries++;
        r = w.row;
        c = w.col;
        if (r >= bh || c >= bw) return;   // outside the box, no result
        s = (reg_window > cbld_pkg::MAX_WINDOW) ? cbld_pkg::MAX_WINDOW : int'(reg_window);
        hit = 0;
        if (shadow_label[r*bw + c] < 0 && shadow_nz[r*bw + c]) begin
            r1 = (r + s < bh) ? r + s : bh;
            c1 = (c + s < bw) ? c + s : bw;
            for (int wr = (r > s ? r - s : 0); wr < r1; wr++)
                for (int wc = (c > s ? c - s : 0); wc < c1; wc++)
                    if (int'(shadow_label[wr*bw + wc]) == int'(reg_blob_id)) hit = 1;
        end
        res.label = hit ? $signed({1'b0, reg_blob_id}) : shadow_label[r*bw + c];
        res.dilated = hit;
        expected_labels.push_back(res);
    endfunction

    // mostly short gaps, a few long ones, none at all in calm stretches
    function automatic int gap_len(bit calm);
        int p;
        if (calm) return 0;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------
    function automatic logic signed [cbld_pkg::LABEL_W-1:0] pick_label(
        logic [cbld_pkg::ID_W-1:0] id
    );
        int p;
        p = $urandom_range(0, 99);
        if (p < 30) return $signed({1'b0, id});
        if (p < 60) return -17'sd1;
        if (p < 70) return -$signed(17'($urandom_range(2, 65536)));
        return $signed({1'b0, 16'($urandom())});
    endfunction

    function automatic t_pending word_item(cbld_pkg::t_opcode op, int row, int col,
                                           logic [cbld_pkg::ID_W-1:0] id);
        t_pending it;
        it.kind  = K_WORD;
        it.op    = op;
        it.value = ($urandom_range(0, 9) < 3) ? 8'd0 :
                   (($urandom_range(0, 9) == 0) ? 8'hff : 8'($urandom_range(1, 255)));
        it.label = pick_label(id);
        it.row   = row[cbld_pkg::COORD_W-1:0];
        it.col   = col[cbld_pkg::COORD_W-1:0];
        it.idx   = cbld_pkg::CFG_BLOB_ID;
        it.data  = '0;
        return it;
    endfunction

    function automatic void add_reg(cbld_pkg::t_cfg_index idx,
                                    logic [cbld_pkg::ID_W-1:0] data);
        t_pending it;
        it = word_item(cbld_pkg::OP_LOAD, 0, 0, '0);
        it.kind = K_REG;
        it.idx  = idx;
        it.data = data;
        pending_words.push_back(it);
    endfunction

    function automatic void add_drain();
        t_pending it;
        it = word_item(cbld_pkg::OP_LOAD, 0, 0, '0);
        it.kind = K_DRAIN;
        pending_words.push_back(it);
    endfunction

    // write all registers, fill the whole box, then run random queries;
    // unused upper data bits carry noise since the block ignores them
    function automatic void add_phase(int bw, int bh, int win, int id, int nq);
        int ew;
        int eh;
        add_reg(cbld_pkg::CFG_BLOB_ID, id[cbld_pkg::ID_W-1:0]);
        add_reg(cbld_pkg::CFG_WINDOW_SIZE, {12'($urandom()), win[cbld_pkg::WIN_W-1:0]});
        add_reg(cbld_pkg::CFG_BOX_WIDTH, {9'($urandom()), bw[cbld_pkg::DIM_W-1:0]});
        add_reg(cbld_pkg::CFG_BOX_HEIGHT, {9'($urandom()), bh[cbld_pkg::DIM_W-1:0]});
        ew = clamp_dim(bw[cbld_pkg::DIM_W-1:0], cbld_pkg::MAX_BOX_WIDTH);
        eh = clamp_dim(bh[cbld_pkg::DIM_W-1:0], cbld_pkg::MAX_BOX_HEIGHT);
        // a full area of loads covers every position whatever the pointer
        for (int k = 0; k < ew * eh; k++)
            pending_words.push_back(word_item(cbld_pkg::OP_LOAD, $urandom_range(0, 63),
                                              $urandom_range(0, 63),
                                              id[cbld_pkg::ID_W-1:0]));
        for (int k = 0; k < nq; k++) begin
            if ($urandom_range(0, 99) < 85)
                pending_words.push_back(word_item(cbld_pkg::OP_QUERY,
                                                  $urandom_range(0, eh - 1),
                                                  $urandom_range(0, ew - 1),
                                                  id[cbld_pkg::ID_W-1:0]));
            else
                pending_words.push_back(word_item(cbld_pkg::OP_QUERY,
                                                  $urandom_range(0, 63),
                                                  $urandom_range(0, 63),
                                                  id[cbld_pkg::ID_W-1:0]));
        end
        n_phases++;
    endfunction

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    t_pending cur_word;
    bit       cur_busy;
    int       cur_gap;
    int       quiet_cycles;
    bit       calm;
    int       calm_left;

    always @(posedge i_clk) begin
        logic push_n;
        logic cfg_valid_n;
        push_n = 1'b0;
        cfg_valid_n = 1'b0;
        if (!i_rst_n) begin
            cur_busy = 0;
            cur_gap = 0;
            quiet_cycles = 0;
            calm = 0;
            calm_left = 0;
        end else begin
            // stretches with and without idling are picked at random
            if (calm_left == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(16, 96);
            end else begin
                calm_left--;
            end
            if (push && !full) begin
                dilate_word(cur_word);
                cur_busy = 0;
                quiet_cycles = 0;
            end else if (expected_labels.size() == 0) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg(cur_word.idx, cur_word.data);
                n_reg_writes++;
                cur_busy = 0;
            end
            if (!cur_busy && pending_words.size() > 0) begin
                cur_word = pending_words.pop_front();
                cur_busy = 1;
                cur_gap = (cur_word.kind == K_WORD) ? gap_len(calm) : 0;
            end
            if (cur_busy && cur_gap > 0) begin
                cur_gap--;
            end else if (cur_busy) begin
                case (cur_word.kind)
                    K_WORD: begin
                        push_n = 1'b1;
                        i_opcode      <= cur_word.op;
                        i_pixel_value <= cur_word.value;
                        i_pixel_label <= cur_word.label;
                        i_query_row   <= cur_word.row;
                        i_query_col   <= cur_word.col;
                    end
                    K_REG: begin
                        // the block must be idle, loads included
                        if (expected_labels.size() == 0 && quiet_cycles >= SETTLE) begin
                            cfg_valid_n = 1'b1;
                            i_cfg_index <= cur_word.idx;
                            i_cfg_data  <= cur_word.data;
                        end
                    end
                    default: begin
                        // hold off until every result is back
                        if (expected_labels.size() == 0) cur_busy = 0;
                    end
                endcase
            end
        end
        push <= push_n;
        i_cfg_valid <= cfg_valid_n;
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        t_dil_result exp_res;
        if (!i_rst_n) begin
            stall_left = 0;
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_results++;
                if (expected_labels.size() == 0) begin
                    errors++;
                    if (mismatches < 10)
                        $display("unexpected result word: label %0d dilated %0b",
                                 o_new_label, o_dilated);
                    mismatches++;
                end else begin
                    exp_res = expected_labels.pop_front();
                    if (o_new_label !== exp_res.label || o_dilated !== exp_res.dilated) begin
                        errors++;
                        if (mismatches < 10)
                            $display({"result mismatch: expected label %0d dilated %0b,",
                                      " got label %0d dilated %0b"},
                                     exp_res.label, exp_res.dilated, o_new_label, o_dilated);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                stall_left = gap_len(calm);
                pop <= (stall_left == 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        errors = 0;
        mismatches = 0;
        n_loads = 0;
        n_queries = 0;
        n_results = 0;
        n_reg_writes = 0;
        n_phases = 0;
        shadow_pos = 0;
        reg_blob_id = 16'd0;
        reg_window = 4'd1;
        reg_width = 7'd64;
        reg_height = 7'd64;

        // directed: small box, corners, center and both out-of-box sides
        add_phase(4, 3, 1, 5, 0);
        pending_words.push_back(word_item(cbld_pkg::OP_QUERY, 0, 0, 16'd5));
        pending_words.push_back(word_item(cbld_pkg::OP_QUERY, 0, 3, 16'd5));
        pending_words.push_back(word_item(cbld_pkg::OP_QUERY, 2, 0, 16'd5));
        pending_words.push_back(word_item(cbld_pkg::OP_QUERY, 2, 3, 16'd5));
        pending_words.push_back(word_item(cbld_pkg::OP_QUERY, 1, 1, 16'd5));
        pending_words.push_back(word_item(cbld_pkg::OP_QUERY, 1, 2, 16'd5));
        pending_words.push_back(word_item(cbld_pkg::OP_QUERY, 3, 0, 16'd5));
        pending_words.push_back(word_item(cbld_pkg::OP_QUERY, 0, 4, 16'd5));
        pending_words.push_back(word_item(cbld_pkg::OP_QUERY, 63, 63, 16'd5));
        // extremes of the registers: full width with widest window,
        // single pixel with empty window, zero and oversized dimensions
        add_phase(64, 2, 15, 16'hffff, 12);
        add_phase(1, 1, 0, 0, 8);
        add_phase(0, 127, 3, 7, 15);
        add_phase(100, 0, 15, 3, 15);

        for (int p = 0; p < 4; p++) begin
            add_phase($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 15),
                      ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 65535), 10);
            if (p == 2) add_drain();
            for (int k = 0; k < 10; k++)
                pending_words.push_back(word_item(cbld_pkg::OP_QUERY, $urandom_range(0, 15),
                                                  $urandom_range(0, 15), 16'd0));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (pending_words.size() > 0 || cur_busy);
        do @(posedge i_clk); while (expected_labels.size() > 0);
        repeat (1000) @(posedge i_clk);

        $display("covered %0d phases with %0d register writes: %0d loads, %0d queries",
                 n_phases, n_reg_writes, n_loads, n_queries);
        $display("%0d results checked, mismatches counted: %0d", n_results, errors);
        if (errors == 0)
            $display("conditional_blob_label_dilation_core regression: pass");
        else
            $display("conditional_blob_label_dilation_core regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("timeout with %0d words pending and %0d results outstanding",
                 pending_words.size(), expected_labels.size());
        $display("conditional_blob_label_dilation_core regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/cbld_pkg.sv
hdl/cbld_ram.sv
hdl/cbld_queue.sv
hdl/cbld_front.sv
hdl/cbld_back.sv
hdl/conditional_blob_label_dilation_core.sv
hdl/cbld_checker.sv
dv/conditional_blob_label_dilation_core_tb.sv
